/* rtl/dfp_pkg.sv */
// Shared types, constants and helpers for the detection frame parser.
package dfp_pkg;

    localparam int unsigned LABEL_LEN_DEF = 6;
    localparam int unsigned LABEL_OUT     = 6;
    localparam int unsigned ROOT_LEN      = 4;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;
    localparam logic [7:0]  TRAILER_RST       = 8'd255;
    localparam logic [15:0] X_LIMIT_RST       = 16'd800;
    localparam logic [15:0] Y_LIMIT_RST       = 16'd480;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT       = 3'd4;

    localparam logic [1:0] CLS_YELLOW  = 2'd0;
    localparam logic [1:0] CLS_ROOT    = 2'd1;
    localparam logic [1:0] CLS_UNKNOWN = 2'd2;

    typedef logic [LABEL_OUT-1:0][7:0] t_word6;

    // byte 0 of a word sits in the top element
    localparam t_word6 WORD_YELLOW = {8'h79, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h77};
    localparam t_word6 WORD_ROOT   = {8'h72, 8'h6F, 8'h6F, 8'h74, 8'h00, 8'h00};

    typedef enum logic [2:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_LABEL,
        PH_XH,
        PH_XL,
        PH_YH,
        PH_YL,
        PH_TAIL
    } t_phase;

    typedef struct packed {
        logic        frame_ok;
        logic [1:0]  class_code;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        t_word6      label_bytes;
    } t_result;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* rtl/dfp_classify.sv */
// Case-folding label classifier: yellow, root or unknown.
module dfp_classify import dfp_pkg::*; (
    input  t_word6     i_label,
    output logic [1:0] o_class_code
);

    logic [LABEL_OUT-1:0] yellow_hit;
    logic [LABEL_OUT-1:0] root_hit;

    always_comb begin
        for (int i = 0; i < LABEL_OUT; i++) begin
            yellow_hit[i] = (fold_case(i_label[i]) == WORD_YELLOW[i]);
            if (i >= LABEL_OUT - ROOT_LEN) begin
                root_hit[i] = (fold_case(i_label[i]) == WORD_ROOT[i]);
            end else begin
                root_hit[i] = 1'b1;
            end
        end
    end

    always_comb begin
        if (&yellow_hit) begin
            o_class_code = CLS_YELLOW;
        end else if (&root_hit) begin
            o_class_code = CLS_ROOT;
        end else begin
            o_class_code = CLS_UNKNOWN;
        end
    end

endmodule

/* rtl/detection_frame_parser_unit.sv */
// Top level of the detection frame parser.
// Usage:
//   Input channel: one received byte per request on i_rx_data, taken when
//   i_rx_valid and o_rx_ready are both high. One byte can be taken each cycle.
//   Frame: header_first, header_second, LABEL_LEN category bytes, X high/low,
//   Y high/low, tail. Only the tail byte yields a result request.
//   Result channel: o_res_valid / i_res_ready with frame_ok, class_code,
//   clamped X, Y and first six category bytes of the last good-tail frame.
//   The tail byte's result is registered in the output register or the skid.
//   Throughput: one byte per cycle while o_rx_ready is high; the frame state
//   machine and the output or skid register update as the byte is taken.
//   Stall: a two-deep result buffer (output register plus skid) keeps input
//   flowing while a result waits; o_rx_ready falls only when both are full.
//   Configuration: i_cfg_we writes register i_cfg_addr at the next edge;
//   write only while the block is idle. Unknown indexes are ignored.
//   Reset: synchronous, active low; config registers return to defaults, the
//   parser waits for header_first and the held X, Y and label are zero.
module detection_frame_parser_unit import dfp_pkg::*; #(
    parameter int unsigned LABEL_LEN = LABEL_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [7:0]            i_rx_data,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_frame_ok,
    output logic [1:0]            o_class_code,
    output logic [15:0]           o_x_coord,
    output logic [15:0]           o_y_coord,
    output logic [47:0]           o_label_bytes
);

    localparam int unsigned CNT_W = $clog2(LABEL_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LABEL_LEN - 1);

    logic [7:0]  r_header_first;
    logic [7:0]  r_header_second;
    logic [7:0]  r_trailer;
    logic [15:0] r_x_limit;
    logic [15:0] r_y_limit;

    t_phase                     r_phase, n_phase;
    logic [CNT_W-1:0]           r_label_cnt;
    logic [LABEL_LEN-1:0][7:0]  r_label;
    logic [31:0]                r_coord;
    logic [15:0]                r_held_x, n_held_x;
    logic [15:0]                r_held_y, n_held_y;
    t_word6                     r_held_label, n_held_label;

    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic   rx_take;
    logic   res_new;
    logic   tail_ok;
    t_word6 label_head;
    logic [1:0] class_raw;
    logic [15:0] x_raw;
    logic [15:0] y_raw;

    assign o_rx_ready = !r_skid_valid;
    assign rx_take    = i_rx_valid && o_rx_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= HEADER_FIRST_RST;
            r_header_second <= HEADER_SECOND_RST;
            r_trailer       <= TRAILER_RST;
            r_x_limit       <= X_LIMIT_RST;
            r_y_limit       <= Y_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_HEADER_FIRST:  r_header_first  <= i_cfg_data[7:0];
                REG_HEADER_SECOND: r_header_second <= i_cfg_data[7:0];
                REG_TRAILER:       r_trailer       <= i_cfg_data[7:0];
                REG_X_LIMIT:       r_x_limit       <= i_cfg_data;
                REG_Y_LIMIT:       r_y_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HEAD1: begin
                if (i_rx_data == r_header_first) begin
                    n_phase = PH_HEAD2;
                end
            end
            PH_HEAD2: begin
                if (i_rx_data == r_header_second) begin
                    n_phase = PH_LABEL;
                end else if (i_rx_data != r_header_first) begin
                    n_phase = PH_HEAD1;
                end
            end
            PH_LABEL: begin
                if (r_label_cnt == CNT_LAST) begin
                    n_phase = PH_XH;
                end
            end
            PH_XH:   n_phase = PH_XL;
            PH_XL:   n_phase = PH_YH;
            PH_YH:   n_phase = PH_YL;
            PH_YL:   n_phase = PH_TAIL;
            PH_TAIL: n_phase = PH_HEAD1;
            default: n_phase = PH_HEAD1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD1;
        end else if (rx_take) begin
            r_phase <= n_phase;
        end
    end

    // label and coordinate capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_cnt <= '0;
            r_label     <= '0;
            r_coord     <= '0;
        end else if (rx_take) begin
            case (r_phase)
                PH_HEAD2: begin
                    if (i_rx_data == r_header_second) begin
                        r_label_cnt <= '0;
                        r_label     <= '0;
                    end
                end
                PH_LABEL: begin
                    r_label[r_label_cnt] <= i_rx_data;
                    r_label_cnt          <= r_label_cnt + 1'b1;
                end
                PH_XH:   r_coord[31:24] <= i_rx_data;
                PH_XL:   r_coord[23:16] <= i_rx_data;
                PH_YH:   r_coord[15:8]  <= i_rx_data;
                PH_YL:   r_coord[7:0]   <= i_rx_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < LABEL_OUT; i++) begin
            label_head[LABEL_OUT-1-i] = r_label[i];
        end
    end

    dfp_classify u_classify (
        .i_label      (label_head),
        .o_class_code (class_raw)
    );

    assign x_raw   = r_coord[31:16];
    assign y_raw   = r_coord[15:0];
    assign tail_ok = (i_rx_data == r_trailer);
    assign res_new = rx_take && (r_phase == PH_TAIL);

    // result and held values
    always_comb begin
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_held_label = r_held_label;
        if (tail_ok) begin
            n_held_x     = (x_raw > r_x_limit) ? r_x_limit : x_raw;
            n_held_y     = (y_raw > r_y_limit) ? r_y_limit : y_raw;
            n_held_label = label_head;
        end
        n_result.frame_ok    = tail_ok;
        n_result.class_code  = tail_ok ? class_raw : CLS_UNKNOWN;
        n_result.x_coord     = n_held_x;
        n_result.y_coord     = n_held_y;
        n_result.label_bytes = n_held_label;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_label <= '0;
        end else if (res_new) begin
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
            r_held_label <= n_held_label;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_res_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_new;
            end
        end else if (res_new) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_res_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_new) begin
                r_out <= n_result;
            end
        end else if (res_new) begin
            r_skid <= n_result;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_frame_ok    = r_out.frame_ok;
    assign o_class_code  = r_out.class_code;
    assign o_x_coord     = r_out.x_coord;
    assign o_y_coord     = r_out.y_coord;
    assign o_label_bytes = r_out.label_bytes;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_bad_tail_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_frame_ok) |-> (o_class_code == CLS_UNKNOWN))
        else $error("tail mismatch reported with a known class");

    a_tail_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_take && r_phase == PH_TAIL) |=> (r_phase == PH_HEAD1 && r_out_valid))
        else $error("tail byte did not rearm parser and post a result");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the detection frame parser: directed and random byte streams.
module testbench import dfp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LABEL_N       = LABEL_LEN_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int FRAME_BYTES   = LABEL_N + 7;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_Y_LIMIT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;
    localparam logic [7:0] EDGE_CHARS [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B,
                                              8'h60, 8'h61, 8'h7A, 8'h7B};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  rx_valid  = 1'b0;
    logic [7:0]            rx_data   = '0;
    logic                  res_ready = 1'b0;
    logic                  rx_ready;
    logic                  res_valid;
    logic                  frame_ok;
    logic [1:0]            class_code;
    logic [15:0]           x_coord;
    logic [15:0]           y_coord;
    logic [47:0]           label_bytes;

    // predictor state and register copies
    logic [7:0]  head_first  = HEADER_FIRST_RST;
    logic [7:0]  head_second = HEADER_SECOND_RST;
    logic [7:0]  tail_byte   = TRAILER_RST;
    logic [15:0] x_max       = X_LIMIT_RST;
    logic [15:0] y_max       = Y_LIMIT_RST;
    t_phase      scan_phase  = PH_HEAD1;
    logic [2:0]  label_fill  = '0;
    logic [7:0]  label_buf [LABEL_N] = '{default: 8'h00};
    logic [31:0] coord_word  = '0;
    logic [15:0] held_x      = '0;
    logic [15:0] held_y      = '0;
    logic [47:0] held_label  = '0;

    t_result due_reports[$];
    int      reports_predicted = 0;
    int      mismatch_count    = 0;
    int      cycle_count       = 0;
    bit      steady            = 1'b0;

    detection_frame_parser_unit #(.LABEL_LEN(LABEL_N)) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .i_rx_valid    (rx_valid),
        .o_rx_ready    (rx_ready),
        .i_rx_data     (rx_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_frame_ok    (frame_ok),
        .o_class_code  (class_code),
        .o_x_coord     (x_coord),
        .o_y_coord     (y_coord),
        .o_label_bytes (label_bytes)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** detection_frame_parser_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        res_ready <= steady || ($urandom_range(99) >= 30);
    end

    function automatic logic [7:0] fold_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | CASE_BIT) : c;
    endfunction

    function automatic bit spells(input t_word6 w, input int n);
        for (int i = 0; i < n; i++) begin
            if (fold_letter(label_buf[i]) != w[LABEL_OUT-1-i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void clear_scan();
        scan_phase = PH_HEAD1;
        label_fill = '0;
        coord_word = '0;
        label_buf  = '{default: 8'h00};
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_HEADER_FIRST:  head_first  = val[7:0];
            REG_HEADER_SECOND: head_second = val[7:0];
            REG_TRAILER:       tail_byte   = val[7:0];
            REG_X_LIMIT:       x_max       = val;
            REG_Y_LIMIT:       y_max       = val;
            default: ;
        endcase
    endfunction

    function void parse_byte(input logic [7:0] b);
        t_result rep;
        case (scan_phase)
            PH_HEAD1: begin
                if (b == head_first) scan_phase = PH_HEAD2;
            end
            PH_HEAD2: begin
                if (b == head_second) begin
                    scan_phase = PH_LABEL;
                    label_fill = '0;
                    label_buf  = '{default: 8'h00};
                end else if (b == head_first) begin
                    scan_phase = PH_HEAD2;
                end else begin
                    scan_phase = PH_HEAD1;
                end
            end
            PH_LABEL: begin
                if (label_fill < LABEL_N) label_buf[label_fill] = b;
                if (label_fill + 1 >= LABEL_N) scan_phase = PH_XH;
                label_fill = label_fill + 3'd1;
            end
            PH_XH: begin
                coord_word[31:24] = b;
                scan_phase = PH_XL;
            end
            PH_XL: begin
                coord_word[23:16] = b;
                scan_phase = PH_YH;
            end
            PH_YH: begin
                coord_word[15:8] = b;
                scan_phase = PH_YL;
            end
            PH_YL: begin
                coord_word[7:0] = b;
                scan_phase = PH_TAIL;
            end
            PH_TAIL: begin
                if (b == tail_byte) begin
                    held_x = (coord_word[31:16] > x_max) ? x_max : coord_word[31:16];
                    held_y = (coord_word[15:0] > y_max) ? y_max : coord_word[15:0];
                    for (int i = 0; i < LABEL_OUT; i++) begin
                        held_label = {held_label[39:0], label_buf[i]};
                    end
                    rep.frame_ok = 1'b1;
                    if (spells(WORD_YELLOW, LABEL_OUT)) begin
                        rep.class_code = CLS_YELLOW;
                    end else if (spells(WORD_ROOT, ROOT_LEN)) begin
                        rep.class_code = CLS_ROOT;
                    end else begin
                        rep.class_code = CLS_UNKNOWN;
                    end
                end else begin
                    rep.frame_ok   = 1'b0;
                    rep.class_code = CLS_UNKNOWN;
                end
                rep.x_coord     = held_x;
                rep.y_coord     = held_y;
                rep.label_bytes = held_label;
                due_reports.push_back(rep);
                reports_predicted = reports_predicted + 1;
                clear_scan();
            end
            default: clear_scan();
        endcase
    endfunction

    function void check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endfunction

    always @(negedge clk) begin : take_result
        t_result want;
        if (rst_n && res_valid === 1'b1 && res_ready) begin
            if (due_reports.size() == 0) begin
                $error("result request with no frame outstanding");
                mismatch_count = mismatch_count + 1;
            end else begin
                want = due_reports.pop_front();
                check_field("frame_ok", 48'(want.frame_ok), 48'(frame_ok));
                check_field("class_code", 48'(want.class_code), 48'(class_code));
                check_field("x_coord", 48'(want.x_coord), 48'(x_coord));
                check_field("y_coord", 48'(want.y_coord), 48'(y_coord));
                check_field("label_bytes", want.label_bytes, label_bytes);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        bit taken;
        while (!steady && $urandom_range(99) < 30) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = (rx_ready === 1'b1);
            @(posedge clk);
        end
        parse_byte(b);
    endtask

    task automatic wait_reports_done();
        rx_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [7:0] h1, input logic [7:0] h2,
                                  input logic [7:0] tl, input logic [15:0] xl,
                                  input logic [15:0] yl);
        logic [CFG_IDX_W-1:0]  idx [7];
        logic [CFG_DATA_W-1:0] val [7];
        idx = '{REG_HEADER_FIRST, REG_HEADER_SECOND, REG_TRAILER, REG_X_LIMIT,
                REG_Y_LIMIT, REG_UNUSED_FIRST, REG_UNUSED_LAST};
        val = '{{8'($urandom), h1}, {8'($urandom), h2}, {8'($urandom), tl}, xl, yl,
                16'($urandom), 16'($urandom)};
        for (int i = 0; i < 7; i++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            set_register(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        return $urandom_range(1) ? (c ^ CASE_BIT) : c;
    endfunction

    function automatic t_word6 pick_label();
        t_word6 lab;
        case ($urandom_range(6))
            0, 1: begin
                lab = WORD_YELLOW;
                for (int i = 0; i < LABEL_OUT; i++) lab[i] = mix_case(lab[i]);
            end
            2, 3: begin
                lab = WORD_ROOT;
                for (int i = LABEL_OUT - ROOT_LEN; i < LABEL_OUT; i++) begin
                    lab[i] = mix_case(lab[i]);
                end
                lab[1:0] = 16'($urandom);
            end
            4: begin
                lab = WORD_YELLOW;
                lab[$urandom_range(LABEL_OUT - 1)] = 8'($urandom);
            end
            5: begin
                for (int i = 0; i < LABEL_OUT; i++) lab[i] = EDGE_CHARS[$urandom_range(7)];
            end
            default: lab = 48'({$urandom(), $urandom()});
        endcase
        return lab;
    endfunction

    function automatic logic [15:0] pick_coord(input logic [15:0] lim);
        case ($urandom_range(6))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return lim;
            3: return lim + 16'd1;
            4: return lim - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input t_word6 lab, input logic [15:0] x,
                              input logic [15:0] y, input bit tail_ok);
        logic [7:0] tail;
        tail = tail_byte;
        if (!tail_ok) begin
            do tail = 8'($urandom); while (tail == tail_byte);
        end
        push_byte(head_first);
        push_byte(head_second);
        for (int i = LABEL_N - 1; i >= 0; i--) begin
            push_byte((i < LABEL_OUT) ? lab[i] : 8'($urandom));
        end
        push_byte(x[15:8]);
        push_byte(x[7:0]);
        push_byte(y[15:8]);
        push_byte(y[7:0]);
        push_byte(tail);
    endtask

    task automatic send_noise();
        logic [7:0] stray;
        do stray = 8'($urandom); while (stray == head_first || stray == head_second);
        case ($urandom_range(3))
            0: repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            1: begin
                push_byte(head_first);
                push_byte(stray);
            end
            2: push_byte(head_first);
            default: begin
                push_byte(head_first);
                push_byte(head_second);
                repeat ($urandom_range(0, 9)) push_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic run_random_frames(input int min_bytes, input int min_reports);
        int sent;
        int first;
        sent  = 0;
        first = reports_predicted;
        while (sent < min_bytes || reports_predicted - first < min_reports) begin
            if ($urandom_range(3) == 0) send_noise();
            send_frame(pick_label(), pick_coord(x_max), pick_coord(y_max),
                       $urandom_range(9) < 8);
            sent = sent + FRAME_BYTES;
            if ($urandom_range(24) == 0) wait_reports_done();
        end
    endtask

    task automatic test_directed_frames();
        push_byte(head_first);
        send_frame({8'h59, 8'h65, 8'h4C, 8'h4C, 8'h6F, 8'h57}, 16'hFFFF, 16'h0000, 1'b1);
        push_byte(head_first);
        push_byte(8'h00);
        send_frame({8'h52, 8'h6F, 8'h4F, 8'h74, 8'h40, 8'h5B}, 16'h0000, 16'hFFFF, 1'b0);
    endtask

    task automatic test_reset_settings();
        run_random_frames(60, 5);
    endtask

    task automatic test_low_settings();
        wait_reports_done();
        write_settings(8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000);
        run_random_frames(60, 5);
    endtask

    task automatic test_high_settings();
        wait_reports_done();
        write_settings(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        run_random_frames(60, 5);
    endtask

    task automatic test_shared_header();
        logic [7:0] h;
        h = 8'($urandom);
        wait_reports_done();
        write_settings(h, h, 8'($urandom), 16'($urandom), 16'($urandom));
        run_random_frames(60, 5);
    endtask

    task automatic test_steady_flow();
        wait_reports_done();
        steady = 1'b1;
        write_settings(8'($urandom), 8'($urandom), 8'($urandom),
                       16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)));
        run_random_frames(60, 5);
        wait_reports_done();
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_frames();
        test_reset_settings();
        test_low_settings();
        test_high_settings();
        test_shared_header();
        test_steady_flow();
        wait_reports_done();
        if (mismatch_count == 0 && due_reports.size() == 0) begin
            $display("** detection_frame_parser_unit: PASSED **");
        end else begin
            $display("** detection_frame_parser_unit: FAILED **");
        end
        $finish;
    end

endmodule
